// File: hw/rtl/guillotine_rect_allocator_core_defines.svh
// Assertion macros shared by the guillotine rectangle allocator RTL.
// No dependencies; included by the controller and the datapath.
`ifndef GUILLOTINE_RECT_ALLOCATOR_CORE_DEFINES_SVH
`define GUILLOTINE_RECT_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define GRA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gra same-cycle check failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define GRA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gra next-cycle check failed");

`endif

// File: hw/rtl/gra_pkg.sv
// Types, constants and helpers for the guillotine rectangle allocator.
// No dependencies; used by the interfaces, controller, datapath and top level.
package gra_pkg;

   localparam int DEFAULT_MAX_FREE_RECTS = 64;
   localparam int DIM_W   = 13;
   localparam int COORD_W = 12;
   localparam int STAT_W  = 2;

   localparam logic [DIM_W-1:0] ATLAS_RESET = 13'd1024;
   localparam logic [DIM_W-1:0] DIM_LIMIT   = 13'd4096;

   // request commands
   localparam logic CMD_RESERVE = 1'b0;
   localparam logic CMD_CLEAR   = 1'b1;

   // csr register indexes
   localparam logic CSR_ATLAS_WIDTH  = 1'b0;
   localparam logic CSR_ATLAS_HEIGHT = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_NOFIT = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
      logic [COORD_W-1:0] x1;
      logic [COORD_W-1:0] y1;
   } rect_type;

   localparam int RECT_W = $bits(rect_type);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_SWAP,
      ST_APP_R,
      ST_APP_B,
      ST_CLEAR,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       req_ready;
      logic       accept;
      logic       clear_write;
      logic       scan_run;
      logic       rd_last;
      logic       swap_write;
      logic       app_right;
      logic       app_bottom;
      logic       set_status;
      status_type status;
      logic       load_rsp;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_valid;
      logic req_clear;
      logic req_zero;
      logic rsp_busy;
      logic scan_done;
      logic found;
      logic overflow;
      logic need_right;
      logic need_bottom;
   } ctrl_sts_type;

   // last inclusive coordinate of an atlas side, size clamped to 1..4096
   function automatic logic [COORD_W-1:0] atlas_last(input logic [DIM_W-1:0] size);
      logic [DIM_W-1:0] clamped;
      clamped = size;
      if (size == '0) clamped = 13'd1;
      else if (size > DIM_LIMIT) clamped = DIM_LIMIT;
      atlas_last = COORD_W'(clamped - 13'd1);
   endfunction

endpackage

// File: hw/rtl/gra_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on gra_pkg for field widths.
interface gra_req_if;
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [gra_pkg::DIM_W-1:0] req_width;
   logic [gra_pkg::DIM_W-1:0] req_height;

   modport source (output valid, cmd, req_width, req_height, input ready);
   modport sink   (input valid, cmd, req_width, req_height, output ready);
endinterface

interface gra_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [gra_pkg::STAT_W-1:0]  status;
   logic [gra_pkg::COORD_W-1:0] corner_x;
   logic [gra_pkg::COORD_W-1:0] corner_y;

   modport source (output valid, status, corner_x, corner_y, input ready);
   modport sink   (input valid, status, corner_x, corner_y, output ready);
endinterface

// File: hw/rtl/gra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/gra_ctrl.sv
// Sequencer of the allocator: init, clear, scan, swap, appends, response.
// Depends on gra_pkg and the assertion macro header.
`include "guillotine_rect_allocator_core_defines.svh"

module gra_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  gra_pkg::ctrl_sts_type sts,
   output gra_pkg::ctrl_cmd_type cmd
);

   gra_pkg::state_type state_ff;
   gra_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gra_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gra_pkg::ST_INIT: state_in = gra_pkg::ST_IDLE;
         gra_pkg::ST_IDLE: begin
            if (sts.req_valid) begin
               if (sts.req_clear)     state_in = gra_pkg::ST_CLEAR;
               else if (sts.req_zero) state_in = gra_pkg::ST_DONE;
               else                   state_in = gra_pkg::ST_SCAN;
            end
         end
         gra_pkg::ST_SCAN: begin
            if (sts.scan_done) begin
               if (!sts.found || sts.overflow) state_in = gra_pkg::ST_DONE;
               else                            state_in = gra_pkg::ST_SWAP;
            end
         end
         gra_pkg::ST_SWAP: begin
            if (sts.need_right)       state_in = gra_pkg::ST_APP_R;
            else if (sts.need_bottom) state_in = gra_pkg::ST_APP_B;
            else                      state_in = gra_pkg::ST_DONE;
         end
         gra_pkg::ST_APP_R: begin
            if (sts.need_bottom) state_in = gra_pkg::ST_APP_B;
            else                 state_in = gra_pkg::ST_DONE;
         end
         gra_pkg::ST_APP_B: state_in = gra_pkg::ST_DONE;
         gra_pkg::ST_CLEAR: state_in = gra_pkg::ST_DONE;
         gra_pkg::ST_DONE: begin
            if (!sts.rsp_busy) state_in = gra_pkg::ST_IDLE;
         end
         default: state_in = gra_pkg::ST_INIT;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.status = gra_pkg::STATUS_OK;
      unique case (state_ff)
         gra_pkg::ST_INIT: cmd.clear_write = 1'b1;
         gra_pkg::ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.accept    = sts.req_valid;
            if (sts.req_valid && !sts.req_clear && sts.req_zero) begin
               cmd.set_status = 1'b1;
               cmd.status     = gra_pkg::STATUS_NOFIT;
            end
         end
         gra_pkg::ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               if (!sts.found) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = gra_pkg::STATUS_NOFIT;
               end else if (sts.overflow) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = gra_pkg::STATUS_FULL;
               end else begin
                  cmd.rd_last = 1'b1;
               end
            end
         end
         gra_pkg::ST_SWAP: begin
            cmd.swap_write = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = gra_pkg::STATUS_OK;
         end
         gra_pkg::ST_APP_R: cmd.app_right = 1'b1;
         gra_pkg::ST_APP_B: cmd.app_bottom = 1'b1;
         gra_pkg::ST_CLEAR: begin
            cmd.clear_write = 1'b1;
            cmd.set_status  = 1'b1;
            cmd.status      = gra_pkg::STATUS_OK;
         end
         gra_pkg::ST_DONE: cmd.load_rsp = !sts.rsp_busy;
         default: cmd = '0;
      endcase
   end

   // a request refused for a full list must never touch the free list
   `GRA_ASSERT_NEXT(a_full_no_swap, clock, reset,
      state_ff == gra_pkg::ST_SCAN && sts.scan_done && sts.overflow,
      state_ff == gra_pkg::ST_DONE)
   // appends only follow a swap or a right append
   `GRA_ASSERT_NEXT(a_append_after_swap, clock, reset,
      state_ff != gra_pkg::ST_SWAP && state_ff != gra_pkg::ST_APP_R,
      state_ff != gra_pkg::ST_APP_R && state_ff != gra_pkg::ST_APP_B)

endmodule

// File: hw/rtl/gra_dp.sv
// Datapath of the allocator: csr registers, free list RAM, scan, splits, response.
// Depends on gra_pkg, gra_ram and the assertion macro header.
`include "guillotine_rect_allocator_core_defines.svh"

module gra_dp #(
   parameter int MAX_FREE_RECTS = gra_pkg::DEFAULT_MAX_FREE_RECTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic                        csr_index,
   input  logic [gra_pkg::DIM_W-1:0]   csr_wdata,
   input  logic                        req_valid,
   input  logic                        req_cmd,
   input  logic [gra_pkg::DIM_W-1:0]   req_width,
   input  logic [gra_pkg::DIM_W-1:0]   req_height,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [gra_pkg::STAT_W-1:0]  rsp_status,
   output logic [gra_pkg::COORD_W-1:0] rsp_corner_x,
   output logic [gra_pkg::COORD_W-1:0] rsp_corner_y,
   input  gra_pkg::ctrl_cmd_type       cmd,
   output gra_pkg::ctrl_sts_type       sts
);

   localparam int AW = $clog2(MAX_FREE_RECTS);
   localparam int CW = $clog2(MAX_FREE_RECTS + 1);
   localparam logic [CW:0] MAX_CNT = (CW + 1)'(MAX_FREE_RECTS);

   // csr registers
   logic [gra_pkg::DIM_W-1:0] atlas_w_ff, atlas_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         atlas_w_ff <= gra_pkg::ATLAS_RESET;
         atlas_h_ff <= gra_pkg::ATLAS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            gra_pkg::CSR_ATLAS_WIDTH:  atlas_w_ff <= csr_wdata;
            gra_pkg::CSR_ATLAS_HEIGHT: atlas_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request and scan state
   logic [gra_pkg::DIM_W-1:0]   req_w_ff, req_h_ff;
   logic                        clear_ff;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               rd_idx_ff, rd_idx_in;
   logic                        eval_vld_ff, eval_vld_in;
   logic [AW-1:0]               eval_idx_ff;
   logic                        found_ff, found_in;
   logic [AW-1:0]               best_idx_ff, best_idx_in;
   logic [gra_pkg::COORD_W-1:0] best_side_ff, best_side_in;
   gra_pkg::rect_type           best_ff, best_in;
   gra_pkg::status_type         pend_ff;

   // response register
   logic                        rsp_vld_ff;
   logic [gra_pkg::STAT_W-1:0]  rsp_status_ff;
   logic [gra_pkg::COORD_W-1:0] rsp_x_ff, rsp_y_ff;

   // memory ports
   logic                          ram_we, ram_re;
   logic [AW-1:0]                 ram_waddr, ram_raddr;
   logic [gra_pkg::RECT_W-1:0]    ram_wdata, ram_rdata;
   gra_pkg::rect_type             entry;

   gra_ram #(
      .WIDTH (gra_pkg::RECT_W),
      .DEPTH (MAX_FREE_RECTS)
   ) u_free_list (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign entry = gra_pkg::rect_type'(ram_rdata);

   // scan evaluation of the entry read last cycle
   logic [gra_pkg::COORD_W-1:0] e_w, e_h, e_side;
   logic                        e_fit, issue;

   assign e_w    = entry.x1 - entry.x0;
   assign e_h    = entry.y1 - entry.y0;
   assign e_side = (e_w > e_h) ? e_w : e_h;
   assign e_fit  = ({1'b0, e_w} + 13'd1 >= req_w_ff) && ({1'b0, e_h} + 13'd1 >= req_h_ff);
   assign issue  = cmd.scan_run && (rd_idx_ff < count_ff);

   // chosen rectangle splits
   logic [gra_pkg::COORD_W-1:0] c_w, c_h;
   logic                        need_right, need_bottom;
   logic [CW:0]                 after_cnt;
   gra_pkg::rect_type           right_rect, bottom_rect, clear_rect;

   assign c_w         = best_ff.x1 - best_ff.x0;
   assign c_h         = best_ff.y1 - best_ff.y0;
   assign need_right  = ({1'b0, c_w} + 13'd1) > req_w_ff;
   assign need_bottom = ({1'b0, c_h} + 13'd1) > req_h_ff;
   assign after_cnt   = {1'b0, count_ff} - (CW + 1)'(1)
                        + (CW + 1)'(need_right) + (CW + 1)'(need_bottom);

   always_comb begin
      right_rect.x0  = best_ff.x0 + req_w_ff[gra_pkg::COORD_W-1:0];
      right_rect.y0  = best_ff.y0;
      right_rect.x1  = best_ff.x1;
      right_rect.y1  = best_ff.y0 + req_h_ff[gra_pkg::COORD_W-1:0] - 12'd1;
      bottom_rect.x0 = best_ff.x0;
      bottom_rect.y0 = best_ff.y0 + req_h_ff[gra_pkg::COORD_W-1:0];
      bottom_rect.x1 = best_ff.x1;
      bottom_rect.y1 = best_ff.y1;
      clear_rect.x0  = '0;
      clear_rect.y0  = '0;
      clear_rect.x1  = gra_pkg::atlas_last(atlas_w_ff);
      clear_rect.y1  = gra_pkg::atlas_last(atlas_h_ff);
   end

   // memory access selection
   always_comb begin
      ram_re    = issue || cmd.rd_last;
      ram_raddr = cmd.rd_last ? AW'(count_ff - CW'(1)) : rd_idx_ff[AW-1:0];
      ram_we    = cmd.clear_write || cmd.swap_write || cmd.app_right || cmd.app_bottom;
      ram_waddr = count_ff[AW-1:0];
      ram_wdata = bottom_rect;
      if (cmd.clear_write) begin
         ram_waddr = '0;
         ram_wdata = clear_rect;
      end else if (cmd.swap_write) begin
         ram_waddr = best_idx_ff;
         ram_wdata = ram_rdata;
      end else if (cmd.app_right) begin
         ram_wdata = right_rect;
      end
   end

   // next values
   always_comb begin
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      eval_vld_in  = issue;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_side_in = best_side_ff;
      best_in      = best_ff;

      if (cmd.clear_write) count_in = CW'(1);
      else if (cmd.swap_write) count_in = count_ff - CW'(1);
      else if (cmd.app_right || cmd.app_bottom) count_in = count_ff + CW'(1);

      if (cmd.accept) begin
         rd_idx_in = '0;
         found_in  = 1'b0;
      end else if (issue) begin
         rd_idx_in = rd_idx_ff + CW'(1);
      end

      if (eval_vld_ff && e_fit && (!found_ff || e_side < best_side_ff)) begin
         found_in     = 1'b1;
         best_idx_in  = eval_idx_ff;
         best_side_in = e_side;
         best_in      = entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= CW'(1);
         rd_idx_ff   <= '0;
         eval_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         count_ff    <= count_in;
         rd_idx_ff   <= rd_idx_in;
         eval_vld_ff <= eval_vld_in;
         found_ff    <= found_in;
         if (cmd.load_rsp)    rsp_vld_ff <= 1'b1;
         else if (rsp_ready)  rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff  <= rd_idx_ff[AW-1:0];
      best_idx_ff  <= best_idx_in;
      best_side_ff <= best_side_in;
      best_ff      <= best_in;
      if (cmd.accept) begin
         req_w_ff <= req_width;
         req_h_ff <= req_height;
         clear_ff <= (req_cmd == gra_pkg::CMD_CLEAR);
      end
      if (cmd.set_status) pend_ff <= cmd.status;
      if (cmd.load_rsp) begin
         rsp_status_ff <= pend_ff;
         if (pend_ff == gra_pkg::STATUS_OK && !clear_ff) begin
            rsp_x_ff <= best_ff.x0;
            rsp_y_ff <= best_ff.y0;
         end else begin
            rsp_x_ff <= '0;
            rsp_y_ff <= '0;
         end
      end
   end

   always_comb begin
      sts.req_valid   = req_valid;
      sts.req_clear   = (req_cmd == gra_pkg::CMD_CLEAR);
      sts.req_zero    = (req_width == '0) || (req_height == '0);
      sts.rsp_busy    = rsp_vld_ff && !rsp_ready;
      sts.scan_done   = (rd_idx_ff == count_ff) && !eval_vld_ff;
      sts.found       = found_ff;
      sts.overflow    = after_cnt > MAX_CNT;
      sts.need_right  = need_right;
      sts.need_bottom = need_bottom;
   end

   assign rsp_valid    = rsp_vld_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_corner_x = rsp_x_ff;
   assign rsp_corner_y = rsp_y_ff;

   `GRA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, {1'b0, count_ff} <= MAX_CNT)
   `GRA_ASSERT_NOW(a_swap_in_list, clock, reset, cmd.swap_write,
      {1'b0, best_idx_ff} < {1'b0, count_ff})
   `GRA_ASSERT_NOW(a_no_rsp_overwrite, clock, reset, cmd.load_rsp,
      !(rsp_vld_ff && !rsp_ready))

endmodule

// File: hw/rtl/guillotine_rect_allocator_core.sv
// Top level of the guillotine rectangle allocator: channels, controller, datapath.
// Depends on gra_pkg, gra_if, gra_ctrl and gra_dp.
//
// Usage: requests arrive on req_ch (valid/ready). cmd CMD_CLEAR resets the free
// list to one rectangle covering the atlas (size from the csr registers, index 0
// width, index 1 height, written through csr_wr_en/csr_index/csr_wdata while idle).
// cmd CMD_RESERVE looks for the best-fitting free rectangle and answers on rsp_ch
// with status and the top-left corner of the granted region.
// A clear writes the whole-atlas rectangle and then loads the response; a
// zero-sized reserve goes straight to the response with STATUS_NOFIT; a reserve
// scans the list at one entry per cycle through the single free-list RAM read
// port, then refuses or moves the last entry into the chosen slot and appends the
// right and bottom remainders as needed; one request is worked on at a time.
// The response sits in an output register, so the next request is taken while it
// waits; a stalled receiver holds the block only when a second response is ready.
// Reset: synchronous; the first cycle after reset writes the whole-atlas
// rectangle into the list and req_ch.ready stays low for that one cycle.
module guillotine_rect_allocator_core #(
   parameter int MAX_FREE_RECTS = gra_pkg::DEFAULT_MAX_FREE_RECTS
) (
   input  logic                      clock,
   input  logic                      reset,
   gra_req_if.sink                   req_ch,
   gra_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [gra_pkg::DIM_W-1:0] csr_wdata
);

   gra_pkg::ctrl_cmd_type cmd;
   gra_pkg::ctrl_sts_type sts;

   gra_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

   gra_dp #(
      .MAX_FREE_RECTS (MAX_FREE_RECTS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_ch.valid),
      .req_cmd      (req_ch.cmd),
      .req_width    (req_ch.req_width),
      .req_height   (req_ch.req_height),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_status   (rsp_ch.status),
      .rsp_corner_x (rsp_ch.corner_x),
      .rsp_corner_y (rsp_ch.corner_y),
      .cmd          (cmd),
      .sts          (sts)
   );

   assign req_ch.ready = cmd.req_ready;

endmodule
